@@ rtl/utf8_codepoint_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent checks that use the clock clk and the reset rst in scope.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the UTF-8 codepoint decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 3;   // up to four results per byte

  localparam logic [CP_W-1:0] REPLACEMENT  = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_LEN2     = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3     = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4     = 21'h010000;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // Open multi-byte sequence
  typedef struct packed {
    logic [CP_W-1:0] partial_value;
    logic [2:0]      sequence_length;
    logic [1:0]      bytes_held;
  } seq_state_t;

  localparam seq_state_t SEQ_IDLE = '{partial_value: '0, sequence_length: SEQ_NONE,
                                      bytes_held: 2'd0};

  // Results of one byte: count-1 replacements, then cp_last
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CP_W-1:0]    cp_last;
  } burst_t;

endpackage

@@ rtl/utf8_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 codepoint decoder
// Turns a UTF-8 byte stream into Unicode scalars, one U+FFFD per bad byte.
// ----------------------------------------------------------------------------
//   channel | handshake           | per request
//   --------+---------------------+------------------------------------------
//   input   | in_valid in_ready   | in_byte, end_of_text
//   output  | out_valid out_ready | codepoint, run_last (last of a byte's burst)
//
// An accepted byte passes the input register, then is decoded into the result
// register, which sends one result per cycle while out_ready is high; a byte
// that yields several results holds input until its last result leaves, and
// ASCII text then flows at one byte per cycle. Reset closes any open sequence
// and empties both registers. Output stalls back up through the input register.
module utf8_codepoint_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [utf8d_pkg::BYTE_W-1:0]     in_byte,
  input  logic                             end_of_text,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [utf8d_pkg::CP_W-1:0]       codepoint,
  output logic                             run_last
);

  `include "utf8_codepoint_decoder_assert.svh"

  logic                          q_valid;
  logic [utf8d_pkg::BYTE_W-1:0]  q_byte;
  logic                          q_eot;
  utf8d_pkg::seq_state_t         state;
  utf8d_pkg::seq_state_t         state_next;
  utf8d_pkg::burst_t             burst;
  logic                          load_ready;
  logic                          advance;
  logic                          seq_open;
  logic                          held_ok;
  logic                          cp_legal;

  assign advance  = q_valid && load_ready;
  assign in_ready = !q_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= in_byte;
      q_eot  <= end_of_text;
    end
  end

  // Advance the open sequence only when the byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utf8d_pkg::SEQ_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  utf8d_decode u_decode (
    .in_byte     (q_byte),
    .end_of_text (q_eot),
    .state       (state),
    .state_next  (state_next),
    .burst       (burst)
  );

  utf8d_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (q_valid),
    .burst      (burst),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .codepoint  (codepoint),
    .run_last   (run_last)
  );

  assign seq_open = (state.sequence_length != utf8d_pkg::SEQ_NONE);
  assign held_ok  = (state.bytes_held != 2'd0) &&
                    ({1'b0, state.bytes_held} < state.sequence_length);
  assign cp_legal = (codepoint <= utf8d_pkg::CP_MAX) &&
                    ((codepoint < utf8d_pkg::SURR_LO) || (codepoint > utf8d_pkg::SURR_HI));

  `UTF8D_ASSERT_NOW(a_held_in_range, seq_open, held_ok, "open sequence holds a bad byte count")
  `UTF8D_ASSERT_NEXT(a_eot_closes, advance && q_eot, !seq_open, "sequence left open after end of text")
  `UTF8D_ASSERT_NOW(a_scalar_legal, out_valid, cp_legal, "result is not a Unicode scalar")

endmodule

@@ rtl/utf8d_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder byte step
// Combinational decode of one byte against the open sequence; gives the
// result burst and the next sequence state.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic [utf8d_pkg::BYTE_W-1:0] in_byte,
  input  logic                         end_of_text,
  input  utf8d_pkg::seq_state_t        state,
  output utf8d_pkg::seq_state_t        state_next,
  output utf8d_pkg::burst_t            burst
);

  logic                          is_cont;
  logic                          f_count;
  logic [utf8d_pkg::CP_W-1:0]    f_cp;
  logic                          f_open;
  utf8d_pkg::seq_state_t         f_state;
  logic [utf8d_pkg::CP_W-1:0]    v;
  logic [2:0]                    held_inc;
  logic                          complete;
  logic [utf8d_pkg::CP_W-1:0]    min_val;
  logic                          bad;

  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign v        = {state.partial_value[utf8d_pkg::CP_W-7:0], in_byte[5:0]};
  assign held_inc = {1'b0, state.bytes_held} + 3'd1;
  assign complete = (held_inc >= state.sequence_length);

  always_comb begin
    case (state.sequence_length)
      utf8d_pkg::SEQ_LEN2: min_val = utf8d_pkg::MIN_LEN2;
      utf8d_pkg::SEQ_LEN3: min_val = utf8d_pkg::MIN_LEN3;
      default:             min_val = utf8d_pkg::MIN_LEN4;
    endcase
  end

  assign bad = (v < min_val) || (v > utf8d_pkg::CP_MAX) ||
               (v inside {[utf8d_pkg::SURR_LO:utf8d_pkg::SURR_HI]});

  // Decode the byte as if no sequence were open
  always_comb begin
    f_count = 1'b1;
    f_cp    = utf8d_pkg::REPLACEMENT;
    f_open  = 1'b0;
    f_state = utf8d_pkg::SEQ_IDLE;
    if (!in_byte[7]) begin
      f_cp = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}}, in_byte};
    end else if (in_byte[7:5] == 3'b110) begin
      f_open  = 1'b1;
      f_state = '{partial_value: {16'd0, in_byte[4:0]},
                  sequence_length: utf8d_pkg::SEQ_LEN2, bytes_held: 2'd1};
    end else if (in_byte[7:4] == 4'b1110) begin
      f_open  = 1'b1;
      f_state = '{partial_value: {17'd0, in_byte[3:0]},
                  sequence_length: utf8d_pkg::SEQ_LEN3, bytes_held: 2'd1};
    end else if (in_byte[7:3] == 5'b11110) begin
      f_open  = 1'b1;
      f_state = '{partial_value: {18'd0, in_byte[2:0]},
                  sequence_length: utf8d_pkg::SEQ_LEN4, bytes_held: 2'd1};
    end
    // A lead that opens a sequence gives no result yet; on end of text it truncates
    if (f_open) begin
      if (end_of_text) begin
        f_open  = 1'b0;
        f_state = utf8d_pkg::SEQ_IDLE;
      end else begin
        f_count = 1'b0;
      end
    end
  end

  always_comb begin
    burst.count   = '0;
    burst.cp_last = utf8d_pkg::REPLACEMENT;
    state_next    = state;
    if (state.sequence_length != utf8d_pkg::SEQ_NONE) begin
      if (is_cont) begin
        if (complete) begin
          if (bad) begin
            burst.count = state.sequence_length;
          end else begin
            burst.count   = 3'd1;
            burst.cp_last = v;
          end
          state_next = utf8d_pkg::SEQ_IDLE;
        end else if (end_of_text) begin
          burst.count = held_inc;
          state_next  = utf8d_pkg::SEQ_IDLE;
        end else begin
          state_next.partial_value = v;
          state_next.bytes_held    = held_inc[1:0];
        end
      end else begin
        // Flush the broken sequence, then decode the byte afresh
        burst.count   = {1'b0, state.bytes_held} + {2'b00, f_count};
        burst.cp_last = f_count ? f_cp : utf8d_pkg::REPLACEMENT;
        state_next    = f_open ? f_state : utf8d_pkg::SEQ_IDLE;
      end
    end else begin
      burst.count   = {2'b00, f_count};
      burst.cp_last = f_cp;
      state_next    = f_open ? f_state : utf8d_pkg::SEQ_IDLE;
    end
  end

endmodule

@@ rtl/utf8d_emit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one burst and hands out its results one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module utf8d_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  utf8d_pkg::burst_t           burst,
  output logic                        load_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8d_pkg::CP_W-1:0]  codepoint,
  output logic                        run_last
);

  logic [utf8d_pkg::COUNT_W-1:0] remaining;
  logic [utf8d_pkg::CP_W-1:0]    cp_last;

  assign out_valid  = (remaining != '0);
  assign run_last   = (remaining == utf8d_pkg::COUNT_W'(1));
  assign codepoint  = run_last ? cp_last : utf8d_pkg::REPLACEMENT;
  // Take a new burst when empty or once the last result leaves
  assign load_ready = !out_valid || (run_last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load && load_ready) begin
      remaining <= burst.count;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - utf8d_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      cp_last <= burst.cp_last;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// UTF-8 codepoint decoder testbench
// Sends byte streams through the decoder while both sides idle at random. The
// expected scalars for each accepted byte are predicted here and held in order.
// Each result is checked field by field against the oldest expected scalar.
// ----------------------------------------------------------------------------
module tb_top;
  import utf8d_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_BYTES   = 400;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } scalar_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

  typedef enum logic [2:0] {
    TXT_VALID, TXT_OVERLONG, TXT_SURROGATE, TXT_ABOVE, TXT_LEAD_RUN, TXT_NOISE
  } text_kind_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              end_of_text = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CP_W-1:0]   codepoint;
  logic              run_last;

  utf8_codepoint_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .codepoint   (codepoint),
    .run_last    (run_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decoder state as predicted
  logic [CP_W-1:0] open_val = '0;
  logic [2:0]      open_len = SEQ_NONE;
  logic [1:0]      open_held = 2'd0;

  scalar_t burst_buf [4];
  int      burst_n;
  scalar_t expected_scalars[$];

  int fail_count   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;

  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_left = 0;

  // Append one byte at the tail of a text
  function automatic void add_byte(ref byte_q_t q, input logic [BYTE_W-1:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void add_scalar(logic [CP_W-1:0] cp);
    burst_buf[burst_n] = '{cp: cp, last: 1'b0};
    burst_n++;
  endfunction

  function automatic void add_fffd(int count);
    for (int k = 0; k < count; k++) add_scalar(REPLACEMENT);
  endfunction

  function automatic void close_seq();
    open_val  = '0;
    open_len  = SEQ_NONE;
    open_held = 2'd0;
  endfunction

  function automatic logic [CP_W-1:0] min_scalar(logic [2:0] len);
    if (len == SEQ_LEN2) return MIN_LEN2;
    if (len == SEQ_LEN3) return MIN_LEN3;
    return MIN_LEN4;
  endfunction

  // Decode a byte as if no sequence were open
  function automatic void decode_start(logic [BYTE_W-1:0] b, logic eot);
    logic [CP_W-1:0] lead_val;
    logic [2:0]      lead_len;
    lead_len = SEQ_NONE;
    lead_val = '0;
    if (!b[7]) begin
      add_scalar(CP_W'(b));
    end else if (b[7:5] == 3'b110) begin
      lead_val = CP_W'(b[4:0]);
      lead_len = SEQ_LEN2;
    end else if (b[7:4] == 4'b1110) begin
      lead_val = CP_W'(b[3:0]);
      lead_len = SEQ_LEN3;
    end else if (b[7:3] == 5'b11110) begin
      lead_val = CP_W'(b[2:0]);
      lead_len = SEQ_LEN4;
    end else begin
      add_scalar(REPLACEMENT);
    end
    if (lead_len != SEQ_NONE) begin
      if (eot) begin
        add_scalar(REPLACEMENT);
      end else begin
        open_val  = lead_val;
        open_len  = lead_len;
        open_held = 2'd1;
      end
    end
  endfunction

  function automatic void predict_byte(logic [BYTE_W-1:0] b, logic eot);
    logic [CP_W-1:0] v;
    int held;
    burst_n = 0;
    if (open_len != SEQ_NONE) begin
      held = int'(open_held);
      if (b[7:6] == 2'b10) begin
        v = {open_val[CP_W-7:0], b[5:0]};
        held++;
        if (held >= int'(open_len)) begin
          if (v < min_scalar(open_len) || v > CP_MAX || (v >= SURR_LO && v <= SURR_HI)) begin
            add_fffd(int'(open_len));
          end else begin
            add_scalar(v);
          end
          close_seq();
        end else if (eot) begin
          add_fffd(held);
          close_seq();
        end else begin
          open_val  = v;
          open_held = 2'(held);
        end
      end else begin
        // flush the held bytes, then decode the breaking byte afresh
        add_fffd(held);
        close_seq();
        decode_start(b, eot);
      end
    end else begin
      decode_start(b, eot);
    end
    if (eot) close_seq();
    if (burst_n > 0) burst_buf[burst_n-1].last = 1'b1;
    for (int k = 0; k < burst_n; k++) begin
      expected_scalars.insert(expected_scalars.size(), burst_buf[k]);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, eot);
    @(negedge clk);
  endtask

  task automatic send_text(input byte_q_t text, input logic eot_last);
    for (int k = 0; k < text.size(); k++) begin
      send_byte(text[k], eot_last && (k == text.size() - 1));
    end
  endtask

  function automatic byte_q_t encode_scalar(logic [CP_W-1:0] cp, int len);
    byte_q_t text;
    case (len)
      1: add_byte(text, {1'b0, cp[6:0]});
      2: begin
        add_byte(text, {3'b110, cp[10:6]});
        add_byte(text, {2'b10, cp[5:0]});
      end
      3: begin
        add_byte(text, {4'b1110, cp[15:12]});
        add_byte(text, {2'b10, cp[11:6]});
        add_byte(text, {2'b10, cp[5:0]});
      end
      default: begin
        add_byte(text, {5'b11110, cp[20:18]});
        add_byte(text, {2'b10, cp[17:12]});
        add_byte(text, {2'b10, cp[11:6]});
        add_byte(text, {2'b10, cp[5:0]});
      end
    endcase
    return text;
  endfunction

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(8, 64);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:    out_ready <= ~out_ready;
    endcase
  end

  always @(posedge clk) begin
    scalar_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_scalars.size() == 0) begin
        $error("unexpected result: codepoint %h run_last %b", codepoint, run_last);
        fail_count++;
      end else begin
        want = expected_scalars.pop_front();
        if (codepoint !== want.cp) begin
          $error("codepoint: expected %h, actual %h", want.cp, codepoint);
          fail_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %b, actual %b", want.last, run_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic test_ascii_and_valid();
    send_text('{8'h00, 8'h7F}, 1'b0);
    send_text('{8'hC2, 8'h80}, 1'b0);
    send_text('{8'hEF, 8'hBF, 8'hBF}, 1'b0);
    send_text('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0);
  endtask

  task automatic test_rejected_forms();
    send_text('{8'hC0, 8'h80}, 1'b0);                // overlong
    send_text('{8'hED, 8'hA0, 8'h80}, 1'b0);         // surrogate
    send_text('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0);  // above the last scalar
  endtask

  task automatic test_stray_and_bad_lead();
    send_text('{8'h80, 8'hFF}, 1'b0);
  endtask

  task automatic test_broken_and_truncated();
    send_text('{8'hF0, 8'h90, 8'h80, 8'hF8}, 1'b0);  // three held, broken by a bad lead
    send_text('{8'hE2, 8'h82}, 1'b1);                // cut short by end of text
    send_text('{8'hC3}, 1'b1);                       // lead on the final byte
  endtask

  task automatic test_random_text();
    byte_q_t    text;
    text_kind_t kind;
    int         pick;
    int         len;
    int         drop;
    int         sent;
    logic       eot;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 15);
      if (pick < 9)       kind = TXT_VALID;
      else if (pick == 9) kind = TXT_OVERLONG;
      else if (pick == 10) kind = TXT_SURROGATE;
      else if (pick == 11) kind = TXT_ABOVE;
      else if (pick < 14) kind = TXT_LEAD_RUN;
      else                kind = TXT_NOISE;
      text.delete();
      case (kind)
        TXT_VALID: begin
          len = $urandom_range(1, 4);
          case (len)
            1: text = encode_scalar(CP_W'($urandom_range(0, 'h7F)), 1);
            2: text = encode_scalar(CP_W'($urandom_range('h80, 'h7FF)), 2);
            3: text = encode_scalar(CP_W'($urandom_range('h800, 'hFFFF)), 3);
            default: text = encode_scalar(CP_W'($urandom_range('h10000, 'h10FFFF)), 4);
          endcase
        end
        TXT_OVERLONG: begin
          len = $urandom_range(2, 4);
          case (len)
            2: text = encode_scalar(CP_W'($urandom_range(0, 'h7F)), 2);
            3: text = encode_scalar(CP_W'($urandom_range(0, 'h7FF)), 3);
            default: text = encode_scalar(CP_W'($urandom_range(0, 'hFFFF)), 4);
          endcase
        end
        TXT_SURROGATE: text = encode_scalar(CP_W'($urandom_range('hD800, 'hDFFF)), 3);
        TXT_ABOVE:     text = encode_scalar(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);
        TXT_LEAD_RUN: begin
          add_byte(text, BYTE_W'($urandom_range('hC0, 'hF7)));
          repeat ($urandom_range(0, 3)) add_byte(text, BYTE_W'($urandom_range('h80, 'hBF)));
        end
        default: begin
          repeat ($urandom_range(1, 3)) add_byte(text, BYTE_W'($urandom_range(0, 255)));
        end
      endcase
      // cut some sequences short, with or without end of text
      pick = $urandom_range(0, 15);
      eot = (pick < 2);
      if ((pick == 0 || pick == 2) && text.size() > 1) begin
        drop = $urandom_range(1, text.size() - 1);
        repeat (drop) void'(text.pop_back());
      end
      send_text(text, eot);
      sent += text.size();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_ascii_and_valid();
    test_rejected_forms();
    test_stray_and_bad_lead();
    test_broken_and_truncated();
    test_random_text();
    in_valid <= 1'b0;
    while (expected_scalars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
